// ===== hdl/bss_pkg.sv =====
// shared types, constants and helpers of the 3x3 box-sum stream
`timescale 1ns / 1ps

package bss_pkg;

  localparam int unsigned MAX_ROW_WIDTH = 1024;
  localparam int unsigned COL_W         = $clog2(MAX_ROW_WIDTH);
  localparam int unsigned WIDTH_W       = 11;
  localparam int unsigned SAMPLE_W      = 32;
  localparam int unsigned COLSUM_W      = 34;
  localparam int unsigned SUM_W         = 36;
  localparam int unsigned ROWS_W        = 2;
  localparam int unsigned LINE_W        = 2 * SAMPLE_W;

  localparam logic [WIDTH_W-1:0] ROW_WIDTH_RESET = WIDTH_W'(64);
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_MIN   = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0] ROW_WIDTH_MAX   = WIDTH_W'(MAX_ROW_WIDTH);
  localparam logic [ROWS_W-1:0]  ROWS_FULL       = ROWS_W'(2);
  localparam logic [COL_W-1:0]   FIRST_OUT_COL   = COL_W'(2);

  // raster position of one item, decided when it is accepted
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             last;
    logic             emit;
  } pos_t;

  // clamp the configured row width to the supported range
  function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] r;
    r = w;
    if (w < ROW_WIDTH_MIN) r = ROW_WIDTH_MIN;
    if (w > ROW_WIDTH_MAX) r = ROW_WIDTH_MAX;
    return r;
  endfunction

endpackage

// ===== hdl/bss_line_ram.sv =====
// generic simple dual-port ram with registered read data
`timescale 1ns / 1ps

module bss_line_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/bss_raster_ctrl.sv =====
// row width register and column / row counters of the raster stream
`timescale 1ns / 1ps

module bss_raster_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bss_pkg::WIDTH_W-1:0] cfg_row_width_i,
  input  logic                        accept_i,
  input  logic                        frame_start_i,
  output bss_pkg::pos_t               pos_o
);

  logic [bss_pkg::WIDTH_W-1:0] row_width_q;
  logic [bss_pkg::COL_W-1:0]   col_q, col_d, col;
  logic [bss_pkg::ROWS_W-1:0]  rows_q, rows_d, rows;
  logic [bss_pkg::WIDTH_W-1:0] width;
  logic                        last;

  always_comb begin
    width = bss_pkg::eff_width(row_width_q);
    col   = frame_start_i ? '0 : col_q;
    rows  = frame_start_i ? '0 : rows_q;
    last  = ({1'b0, col} + bss_pkg::WIDTH_W'(1)) >= width;

    pos_o.col  = col;
    pos_o.last = last;
    pos_o.emit = (rows == bss_pkg::ROWS_FULL) && (col >= bss_pkg::FIRST_OUT_COL);

    col_d  = col_q;
    rows_d = rows_q;
    if (accept_i) begin
      if (last) begin
        col_d  = '0;
        rows_d = (rows == bss_pkg::ROWS_FULL) ? rows : rows + bss_pkg::ROWS_W'(1);
      end else begin
        col_d  = col + bss_pkg::COL_W'(1);
        rows_d = rows;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= bss_pkg::ROW_WIDTH_RESET;
      col_q       <= '0;
      rows_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        row_width_q <= cfg_row_width_i;
      end
      col_q  <= col_d;
      rows_q <= rows_d;
    end
  end

endmodule

// ===== hdl/bss_window_acc.sv =====
// horizontal accumulation of column sums and the output register
`timescale 1ns / 1ps

module bss_window_acc (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                advance_i,
  input  logic                                valid_i,
  input  logic signed [bss_pkg::COLSUM_W-1:0] colsum_i,
  input  bss_pkg::pos_t                       pos_i,
  output logic                                out_valid_o,
  output logic signed [bss_pkg::SUM_W-1:0]    window_sum_o,
  output logic [bss_pkg::COL_W-1:0]           out_column_o,
  output logic                                row_end_o
);

  logic                                s2_valid_q;
  logic signed [bss_pkg::COLSUM_W-1:0] s2_colsum_q;
  bss_pkg::pos_t                       s2_pos_q;
  logic signed [bss_pkg::COLSUM_W-1:0] prev_q, prev2_q;
  logic signed [bss_pkg::SUM_W-1:0]    total;
  logic                                out_valid_q;
  logic signed [bss_pkg::SUM_W-1:0]    sum_q;
  logic [bss_pkg::COL_W-1:0]           column_q;
  logic                                row_end_q;

  // history always comes from the same row when a result is due
  assign total = bss_pkg::SUM_W'(s2_colsum_q) + bss_pkg::SUM_W'(prev_q)
               + bss_pkg::SUM_W'(prev2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance_i) begin
      s2_valid_q  <= valid_i;
      out_valid_q <= s2_valid_q && s2_pos_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s2_colsum_q <= colsum_i;
      s2_pos_q    <= pos_i;
      sum_q       <= total;
      column_q    <= s2_pos_q.col - bss_pkg::FIRST_OUT_COL;
      row_end_q   <= s2_pos_q.last;
      if (s2_valid_q) begin
        prev_q  <= s2_colsum_q;
        prev2_q <= prev_q;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_sum_o = sum_q;
  assign out_column_o = column_q;
  assign row_end_o    = row_end_q;

endmodule

// ===== hdl/box_sum_3x3_stream.sv =====
// top level of the 3x3 box-sum filter over a raster stream
`timescale 1ns / 1ps

// Takes one signed 32-bit element per clock in row-major order and, once two
// full rows of a frame have been seen, gives for every element at column 2 or
// later the sum of the 3x3 window ending there. One item is accepted every
// cycle the output side is not stalled; it then moves through the line-store
// read register, the column sum register and the output register that holds
// the window sum. The two previous rows share one 1024 x 64 line ram that is
// read at the item's column when it is accepted and written back there; a
// write-to-read bypass covers the same column being read right as it is written
// back (frame start on column zero). The user must write the row width register
// only while the block is idle; the block itself does not enforce it.
module box_sum_3x3_stream (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bss_pkg::WIDTH_W-1:0]         cfg_row_width_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [bss_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                frame_start_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bss_pkg::SUM_W-1:0]    window_sum_o,
  output logic [bss_pkg::COL_W-1:0]           out_column_o,
  output logic                                row_end_o
);

  logic                                advance;
  logic                                in_accept;
  bss_pkg::pos_t                       pos;
  logic                                s1_valid_q;
  logic signed [bss_pkg::SAMPLE_W-1:0] s1_sample_q;
  bss_pkg::pos_t                       s1_pos_q;
  logic                                s1_fwd_q;
  logic [bss_pkg::LINE_W-1:0]          s1_fwd_data_q;
  logic [bss_pkg::LINE_W-1:0]          rdata;
  logic [bss_pkg::LINE_W-1:0]          line;
  logic [bss_pkg::LINE_W-1:0]          wdata;
  logic                                we;
  logic signed [bss_pkg::SAMPLE_W-1:0] up, lo;
  logic signed [bss_pkg::COLSUM_W-1:0] colsum;

  assign advance     = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !advance;
  assign in_accept   = in_valid_i && advance;
  assign cfg_ready_o = 1'b1;

  bss_raster_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_row_width_i (cfg_row_width_i),
    .accept_i        (in_accept),
    .frame_start_i   (frame_start_i),
    .pos_o           (pos)
  );

  // upper half holds the row two back, lower half the row one back
  bss_line_ram #(
    .DEPTH (bss_pkg::MAX_ROW_WIDTH),
    .WIDTH (bss_pkg::LINE_W)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (s1_pos_q.col),
    .wdata_i (wdata),
    .re_i    (in_accept),
    .raddr_i (pos.col),
    .rdata_o (rdata)
  );

  always_comb begin
    line   = s1_fwd_q ? s1_fwd_data_q : rdata;
    up     = line[bss_pkg::LINE_W-1:bss_pkg::SAMPLE_W];
    lo     = line[bss_pkg::SAMPLE_W-1:0];
    wdata  = {lo, s1_sample_q};
    we     = advance && s1_valid_q;
    colsum = bss_pkg::COLSUM_W'(up) + bss_pkg::COLSUM_W'(lo)
           + bss_pkg::COLSUM_W'(s1_sample_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_sample_q   <= sample_i;
      s1_pos_q      <= pos;
      // the read at this edge sees the old entry when it is written back now
      s1_fwd_q      <= we && (s1_pos_q.col == pos.col);
      s1_fwd_data_q <= wdata;
    end
  end

  bss_window_acc u_acc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .valid_i      (s1_valid_q),
    .colsum_i     (colsum),
    .pos_i        (s1_pos_q),
    .out_valid_o  (out_valid_o),
    .window_sum_o (window_sum_o),
    .out_column_o (out_column_o),
    .row_end_o    (row_end_o)
  );

  // input side only waits on a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // an accepted transfer enters the read stage
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted item missing from read stage");

  // window corner column stays inside the widest row
  a_out_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_column_o <= bss_pkg::COL_W'(bss_pkg::MAX_ROW_WIDTH - 3)))
    else $error("output column out of range");

endmodule

// ===== tb/sv/tb_box_sum_3x3_stream.sv =====
// self-checking testbench of the 3x3 box-sum stream filter
`timescale 1ns / 1ps

module tb_box_sum_3x3_stream;
  import bss_pkg::*;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned RANDOM_ITEMS   = 950;
  localparam int unsigned CALM_AFTER     = 750;
  localparam int unsigned PRESSURE_ITEMS = 128;
  localparam int unsigned HOLD_AT        = 36;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_GIVEN} check_kind_e;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [COL_W-1:0]        col;
    logic                    row_end;
  } window_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       fs;
    check_kind_e                kind;
    window_t                    given;
  } stim_t;

  localparam window_t FULL_TOP    = '{36'sd19327352823, '0, 1'b1};
  localparam window_t FULL_BOTTOM = '{-36'sd19327352832, '0, 1'b1};

  // rows of three: a frame of all maximum, a frame of all minimum, a fourth row,
  // then a frame start in the middle of a row
  stim_t directed_rows [25] = '{
    '{S_MAX, 1'b1, CHK_NONE, '0}, '{S_MAX, 1'b0, CHK_NONE, '0},
    '{S_MAX, 1'b0, CHK_NONE, '0}, '{S_MAX, 1'b0, CHK_NONE, '0},
    '{S_MAX, 1'b0, CHK_NONE, '0}, '{S_MAX, 1'b0, CHK_NONE, '0},
    '{S_MAX, 1'b0, CHK_NONE, '0}, '{S_MAX, 1'b0, CHK_NONE, '0},
    '{S_MAX, 1'b0, CHK_GIVEN, FULL_TOP},
    '{S_MIN, 1'b1, CHK_NONE, '0}, '{S_MIN, 1'b0, CHK_NONE, '0},
    '{S_MIN, 1'b0, CHK_NONE, '0}, '{S_MIN, 1'b0, CHK_NONE, '0},
    '{S_MIN, 1'b0, CHK_NONE, '0}, '{S_MIN, 1'b0, CHK_NONE, '0},
    '{S_MIN, 1'b0, CHK_NONE, '0}, '{S_MIN, 1'b0, CHK_NONE, '0},
    '{S_MIN, 1'b0, CHK_GIVEN, FULL_BOTTOM},
    '{32'sd5, 1'b0, CHK_MODEL, '0}, '{-32'sd1, 1'b0, CHK_MODEL, '0},
    '{S_MAX, 1'b0, CHK_MODEL, '0}, '{32'sd77, 1'b0, CHK_MODEL, '0},
    '{-32'sd9, 1'b1, CHK_MODEL, '0}, '{32'sd3, 1'b0, CHK_MODEL, '0},
    '{S_MIN, 1'b0, CHK_MODEL, '0}
  };

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [WIDTH_W-1:0]         cfg_row_width_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_i;
  logic                       frame_start_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SUM_W-1:0]    window_sum_o;
  logic [COL_W-1:0]           out_column_o;
  logic                       row_end_o;

  box_sum_3x3_stream uut (.*);

  // raster state of the filter as the testbench sees it
  logic signed [SAMPLE_W-1:0] two_rows_up [MAX_ROW_WIDTH];
  logic signed [SAMPLE_W-1:0] one_row_up [MAX_ROW_WIDTH];
  logic signed [COLSUM_W-1:0] colsum_left;
  logic signed [COLSUM_W-1:0] colsum_left2;
  int unsigned                raster_col;
  int unsigned                full_rows;
  logic [WIDTH_W-1:0]         width_setting;

  window_t     pending_windows [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned active_width(input logic [WIDTH_W-1:0] w);
    if (w < ROW_WIDTH_MIN) return ROW_WIDTH_MIN;
    if (w > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
    return w;
  endfunction

  // advance the raster by one element; returns 1 when a window is complete
  function automatic logic slide_window(input logic signed [SAMPLE_W-1:0] value,
                                        input logic fs, output window_t res);
    int unsigned                w;
    int unsigned                c;
    logic signed [COLSUM_W-1:0] up;
    logic signed [COLSUM_W-1:0] lo;
    logic signed [COLSUM_W-1:0] cs;
    logic signed [SUM_W-1:0]    total;
    logic                       at_end;
    logic                       hit;
    w = active_width(width_setting);
    if (fs) begin
      raster_col = 0;
      full_rows = 0;
      colsum_left = '0;
      colsum_left2 = '0;
    end
    c = raster_col;
    // a shrunken width ends the row at whatever column it has reached
    at_end = (c + 1 >= w);
    up = two_rows_up[c];
    lo = one_row_up[c];
    two_rows_up[c] = one_row_up[c];
    one_row_up[c] = value;
    cs = up + lo + value;
    hit = (full_rows >= ROWS_FULL) && (c >= FIRST_OUT_COL);
    total = cs;
    total = total + colsum_left + colsum_left2;
    res = '{total, COL_W'(c - FIRST_OUT_COL), at_end};
    colsum_left2 = colsum_left;
    colsum_left = cs;
    if (at_end) begin
      raster_col = 0;
      if (full_rows < ROWS_FULL) full_rows++;
    end else begin
      raster_col = c + 1;
    end
    return hit;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int tmp;
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: begin
        tmp = $urandom_range(0, 16);
        return tmp - 8;
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_t raster_item(input logic signed [SAMPLE_W-1:0] value,
                                        input logic fs);
    return '{value, fs, CHK_MODEL, '0};
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input stim_t item);
    window_t res;
    logic    hit;
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= item.value;
    frame_start_i <= item.fs;
    do @(posedge clk_i); while (in_stall_o);
    hit = slide_window(item.value, item.fs, res);
    case (item.kind)
      CHK_MODEL: if (hit) pending_windows.push_back(res);
      CHK_GIVEN: pending_windows.push_back(item.given);
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // elements that close no window may still be in flight after the last result
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (pending_windows.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_row_width(input logic [WIDTH_W-1:0] w);
    wait_for_drain();
    cfg_valid_i <= 1'b1;
    cfg_row_width_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    width_setting = w;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // new width, then whole frames with the odd truncated frame or early restart
  task automatic run_phase(input logic [WIDTH_W-1:0] w_reg, input int unsigned budget,
                           output int unsigned sent);
    int unsigned w;
    int unsigned frame_len;
    w = active_width(w_reg);
    write_row_width(w_reg);
    sent = 0;
    while (sent < budget) begin
      frame_len = $urandom_range(3, 6) * w;
      if ($urandom_range(0, 5) == 0) frame_len = $urandom_range(1, frame_len);
      for (int k = 0; k < frame_len; k++) begin
        send_item(raster_item(pick_sample(), (k == 0) || ($urandom_range(0, 59) == 0)));
      end
      sent += frame_len;
    end
  endtask

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    window_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_windows.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: sum %0d column %0d",
                                window_sum_o, out_column_o));
      end else begin
        want = pending_windows.pop_front();
        if (window_sum_o !== want.sum)
          flag_mismatch($sformatf("window_sum %0d, expected %0d", window_sum_o, want.sum));
        if (out_column_o !== want.col)
          flag_mismatch($sformatf("out_column %0d, expected %0d", out_column_o, want.col));
        if (row_end_o !== want.row_end)
          flag_mismatch($sformatf("row_end %0b, expected %0b", row_end_o, want.row_end));
      end
    end
  end

  initial begin
    int unsigned        done_random;
    int unsigned        sent;
    logic [WIDTH_W-1:0] w_pick;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_i = '0;
    frame_start_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_row_width_i = '0;
    width_setting = ROW_WIDTH_RESET;
    colsum_left = '0;
    colsum_left2 = '0;
    raster_col = 0;
    full_rows = 0;
    for (int i = 0; i < MAX_ROW_WIDTH; i++) begin
      two_rows_up[i] = '0;
      one_row_up[i] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // a width below the minimum acts as rows of three
    write_row_width('0);
    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // width shrinks while the column counter is already past the new width
    write_row_width(11'd8);
    for (int k = 0; k < 23; k++) send_item(raster_item(pick_sample(), k == 0));
    write_row_width(11'd4);
    for (int k = 0; k < 9; k++) send_item(raster_item(pick_sample(), 1'b0));

    // results are due while the receiver holds off, so the block backs up its input
    write_row_width(11'd16);
    for (int k = 0; k < PRESSURE_ITEMS; k++) begin
      if (k == HOLD_AT) hold_req = 1'b1;
      send_item(raster_item(pick_sample(), k == 0));
    end

    done_random = 0;
    while (done_random < RANDOM_ITEMS) begin
      if (done_random >= CALM_AFTER) calm = 1'b1;
      case ($urandom_range(0, 9))
        0: w_pick = $urandom_range(0, 2);
        1: w_pick = $urandom_range(13, 40);
        default: w_pick = $urandom_range(3, 12);
      endcase
      run_phase(w_pick, $urandom_range(60, 200), sent);
      done_random += sent;
    end

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
